// File: rtl/color_sensor_normalizer_macros.svh
// Assertion macros shared by the colour sensor normaliser RTL.
// Included by the top level; depends on nothing else.
`ifndef COLOR_SENSOR_NORMALIZER_MACROS_SVH
`define COLOR_SENSOR_NORMALIZER_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define CSN_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must be followed in the next cycle by a consequence.
`define CSN_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/csn_pkg.sv
// Package for the colour sensor normaliser: widths, reset values, register
// indices and sequencer states. Depends on nothing.
`timescale 1ns / 1ps

package csn_pkg;

   // Field widths.
   localparam int COUNT_WIDTH     = 16;
   localparam int LEVEL_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 4;

   // Three colour channels go through the shared divider in turn.
   localparam int NUM_CHAN      = 3;
   localparam int CHAN_WIDTH    = $clog2(NUM_CHAN);
   localparam int BIT_CNT_WIDTH = $clog2(LEVEL_WIDTH);

   localparam logic [CHAN_WIDTH-1:0]    LAST_CHAN = CHAN_WIDTH'(NUM_CHAN - 1);
   localparam logic [BIT_CNT_WIDTH-1:0] LAST_BIT  = BIT_CNT_WIDTH'(LEVEL_WIDTH - 1);
   localparam logic [LEVEL_WIDTH-1:0]   LEVEL_MAX = '1;

   // Register reset values.
   localparam logic [COUNT_WIDTH-1:0] DARK_THRESHOLD_RESET   = 16'd60;
   localparam logic [COUNT_WIDTH-1:0] BRIGHT_LOW_RESET       = 16'd5000;
   localparam logic [COUNT_WIDTH-1:0] BRIGHT_HIGH_RESET      = 16'd9000;
   localparam logic [COUNT_WIDTH-1:0] STABILITY_WINDOW_RESET = 16'd1000;

   // Configuration register indices.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DARK_THRESHOLD   = 4'd0,
      CSR_BRIGHT_LOW       = 4'd1,
      CSR_BRIGHT_HIGH      = 4'd2,
      CSR_STABILITY_WINDOW = 4'd3
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/csn_if.sv
// Valid/ready channel interfaces for the colour sensor normaliser: one for
// readings, one for results. Depends on csn_pkg.
`timescale 1ns / 1ps

interface csn_req_if;
   logic                             valid;
   logic                             ready;
   logic                             paused;
   logic [csn_pkg::COUNT_WIDTH-1:0]  red_count;
   logic [csn_pkg::COUNT_WIDTH-1:0]  green_count;
   logic [csn_pkg::COUNT_WIDTH-1:0]  blue_count;
   logic [csn_pkg::COUNT_WIDTH-1:0]  clear_count;

   modport source (
      output valid, paused, red_count, green_count, blue_count, clear_count,
      input  ready
   );
   modport sink (
      input  valid, paused, red_count, green_count, blue_count, clear_count,
      output ready
   );
endinterface

interface csn_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             lamp_on;
   logic                             color_valid;
   logic [csn_pkg::LEVEL_WIDTH-1:0]  red_level;
   logic [csn_pkg::LEVEL_WIDTH-1:0]  green_level;
   logic [csn_pkg::LEVEL_WIDTH-1:0]  blue_level;

   modport source (
      output valid, lamp_on, color_valid, red_level, green_level, blue_level,
      input  ready
   );
   modport sink (
      input  valid, lamp_on, color_valid, red_level, green_level, blue_level,
      output ready
   );
endinterface

// File: rtl/color_sensor_normalizer.sv
// Colour sensor normaliser top level: lamp control, colour capture and a
// shared restoring divider. Depends on csn_pkg, csn_if and the macro header.
//
//   channel   direction  beat contents
//   req_bus   in         paused, red/green/blue/clear counts
//   rsp_bus   out        lamp_on, color_valid, red/green/blue levels
//   csr_*     in         write enable, register index, 16-bit data
//
// An unpaused reading with a valid colour passes from acceptance to the result
// register through, per channel, one compare step and, unless the level
// saturates, eight quotient bits from the single shared subtractor, then one load
// step. Paused or invalid readings go straight to the load. A new reading is
// taken at the earliest in the cycle after the load, not while one is in flight;
// the load waits while an earlier result is still unaccepted. The result register
// lets the next reading be accepted while a result waits. Reset is synchronous and
// clears the lamp, capture state and registers to their defaults.
`timescale 1ns / 1ps
`include "color_sensor_normalizer_macros.svh"

module color_sensor_normalizer (
   input  logic                                  clock,
   input  logic                                  reset,
   csn_req_if.sink                               req_bus,
   csn_rsp_if.source                             rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [csn_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [csn_pkg::COUNT_WIDTH-1:0]       csr_write_data
);

   localparam int CW  = csn_pkg::COUNT_WIDTH;
   localparam int LW  = csn_pkg::LEVEL_WIDTH;
   localparam int CHW = csn_pkg::CHAN_WIDTH;
   localparam int BCW = csn_pkg::BIT_CNT_WIDTH;

   // Configuration registers.
   logic [CW-1:0] dark_threshold_ff, bright_low_ff;
   logic [CW-1:0] bright_high_ff, stability_window_ff;

   // Persistent state.
   logic          lamp_ff, lamp_in;
   logic          stable_ff, stable_in;
   logic [CW-1:0] prev_clear_ff, prev_clear_in;
   logic [CW-1:0] held_ff [csn_pkg::NUM_CHAN];
   logic          capture;

   // Sequencer and divider.
   csn_pkg::state_type                 state_ff, state_in;
   logic [csn_pkg::CHAN_WIDTH-1:0]     chan_ff, chan_in;
   logic [csn_pkg::BIT_CNT_WIDTH-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0]                      clear_ff, clear_in;
   logic [CW-1:0]                      rem_ff, rem_in;
   logic [LW-1:0]                      quot_ff, quot_in;
   logic [LW-1:0]                      level_ff [csn_pkg::NUM_CHAN];
   logic [LW-1:0]                      level_in;
   logic                               level_we;
   logic                               color_ok_ff, color_ok_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_lamp_ff, rsp_color_ff;
   logic [LW-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   logic          accept, out_free, out_load;
   logic [CW-1:0] req_clear, abs_diff, held_sel;
   logic [CW:0]   sub_a;
   logic [CW+1:0] sub_res;
   logic          borrow;

   // Terms used by the checks.
   logic          seq_busy, rem_ok, levels_zero;

   assign accept    = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign out_load  = (state_ff == csn_pkg::ST_FINISH) && out_free;
   assign req_clear = req_bus.clear_count;

   // Configuration writes; unknown indices are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_threshold_ff   <= csn_pkg::DARK_THRESHOLD_RESET;
         bright_low_ff       <= csn_pkg::BRIGHT_LOW_RESET;
         bright_high_ff      <= csn_pkg::BRIGHT_HIGH_RESET;
         stability_window_ff <= csn_pkg::STABILITY_WINDOW_RESET;
      end else if (csr_write_enable) begin
         case (csn_pkg::csr_index_type'(csr_index))
            csn_pkg::CSR_DARK_THRESHOLD:   dark_threshold_ff   <= csr_write_data;
            csn_pkg::CSR_BRIGHT_LOW:       bright_low_ff       <= csr_write_data;
            csn_pkg::CSR_BRIGHT_HIGH:      bright_high_ff      <= csr_write_data;
            csn_pkg::CSR_STABILITY_WINDOW: stability_window_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Lamp hysteresis and stability test for an accepted reading.
   always_comb begin
      abs_diff = (prev_clear_ff >= req_clear) ? (prev_clear_ff - req_clear)
                                              : (req_clear - prev_clear_ff);
      lamp_in       = lamp_ff;
      stable_in     = stable_ff;
      prev_clear_in = prev_clear_ff;
      capture       = 1'b0;
      if (accept && !req_bus.paused) begin
         if (req_clear != '0 && req_clear < dark_threshold_ff) begin
            lamp_in = 1'b1;
         end else if (req_clear > bright_low_ff && req_clear < bright_high_ff) begin
            lamp_in = 1'b0;
         end
         if (lamp_in) begin
            if (abs_diff < stability_window_ff) begin
               stable_in = 1'b1;
               capture   = 1'b1;
            end
            prev_clear_in = req_clear;
         end else begin
            stable_in = 1'b0;
         end
      end
   end

   // The shared subtractor: a saturation test in setup, a quotient bit in divide.
   always_comb begin
      held_sel = held_ff[chan_ff];
      sub_a    = (state_ff == csn_pkg::ST_SETUP) ? {1'b0, held_sel} : {rem_ff, 1'b0};
      sub_res  = {1'b0, sub_a} - {2'b00, clear_ff};
      borrow   = sub_res[CW+1];
   end

   // Datapath next values.
   always_comb begin
      chan_in     = chan_ff;
      bit_cnt_in  = bit_cnt_ff;
      clear_in    = clear_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      color_ok_in = color_ok_ff;
      level_in    = csn_pkg::LEVEL_MAX;
      level_we    = 1'b0;
      case (state_ff)
         csn_pkg::ST_IDLE: begin
            if (accept) begin
               clear_in    = req_clear;
               chan_in     = '0;
               color_ok_in = !req_bus.paused && stable_in;
            end
         end
         csn_pkg::ST_SETUP: begin
            rem_in     = held_sel;
            quot_in    = '0;
            bit_cnt_in = '0;
            if (!borrow) begin
               // Held count at or above clear: quotient would exceed the range.
               level_we = 1'b1;
               chan_in  = chan_ff + CHW'(1);
            end
         end
         csn_pkg::ST_DIVIDE: begin
            if (!borrow) begin
               rem_in = sub_res[CW-1:0];
            end else begin
               rem_in = sub_a[CW-1:0];
            end
            quot_in    = {quot_ff[LW-2:0], !borrow};
            bit_cnt_in = bit_cnt_ff + BCW'(1);
            if (bit_cnt_ff == csn_pkg::LAST_BIT) begin
               level_in = quot_in;
               level_we = 1'b1;
               chan_in  = chan_ff + CHW'(1);
            end
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csn_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (!req_bus.paused && stable_in) ? csn_pkg::ST_SETUP
                                                         : csn_pkg::ST_FINISH;
            end
         end
         csn_pkg::ST_SETUP: begin
            if (borrow) begin
               state_in = csn_pkg::ST_DIVIDE;
            end else if (chan_ff == csn_pkg::LAST_CHAN) begin
               state_in = csn_pkg::ST_FINISH;
            end
         end
         csn_pkg::ST_DIVIDE: begin
            if (bit_cnt_ff == csn_pkg::LAST_BIT) begin
               state_in = (chan_ff == csn_pkg::LAST_CHAN) ? csn_pkg::ST_FINISH
                                                          : csn_pkg::ST_SETUP;
            end
         end
         csn_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = csn_pkg::ST_IDLE;
            end
         end
         default: state_in = csn_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_bus.ready = (state_ff == csn_pkg::ST_IDLE);
      rsp_valid_in  = out_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= csn_pkg::ST_IDLE;
         lamp_ff       <= 1'b0;
         stable_ff     <= 1'b0;
         prev_clear_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < csn_pkg::NUM_CHAN; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         lamp_ff       <= lamp_in;
         stable_ff     <= stable_in;
         prev_clear_ff <= prev_clear_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (capture) begin
            held_ff[0] <= req_bus.red_count;
            held_ff[1] <= req_bus.green_count;
            held_ff[2] <= req_bus.blue_count;
         end
      end
   end

   // Divider and result payload registers.
   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      bit_cnt_ff  <= bit_cnt_in;
      clear_ff    <= clear_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      color_ok_ff <= color_ok_in;
      if (level_we) begin
         level_ff[chan_ff] <= level_in;
      end
      if (accept) begin
         rsp_lamp_ff <= lamp_in;
      end
      if (out_load) begin
         rsp_color_ff <= color_ok_ff;
         rsp_red_ff   <= color_ok_ff ? level_ff[0] : '0;
         rsp_green_ff <= color_ok_ff ? level_ff[1] : '0;
         rsp_blue_ff  <= color_ok_ff ? level_ff[2] : '0;
      end
   end

   // The lamp state of a result is taken at acceptance and copied at load.
   logic rsp_lamp_out_ff;
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_lamp_out_ff <= rsp_lamp_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.lamp_on     = rsp_lamp_out_ff;
   assign rsp_bus.color_valid = rsp_color_ff;
   assign rsp_bus.red_level   = rsp_red_ff;
   assign rsp_bus.green_level = rsp_green_ff;
   assign rsp_bus.blue_level  = rsp_blue_ff;

   // Checks on the sequencer and divider.
   assign seq_busy    = (state_ff != csn_pkg::ST_IDLE);
   assign rem_ok      = (state_ff != csn_pkg::ST_DIVIDE) || (rem_ff < clear_ff);
   assign levels_zero = !rsp_bus.valid || rsp_bus.color_valid
                        || (rsp_bus.red_level == '0 && rsp_bus.green_level == '0
                            && rsp_bus.blue_level == '0);

   `CSN_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, seq_busy, "still idle")
   `CSN_ASSERT(a_rem_below_divisor, clock, reset, rem_ok, "remainder not below clear")
   `CSN_ASSERT(a_invalid_levels_zero, clock, reset, levels_zero, "levels without colour")

endmodule

// File: bench/color_sensor_normalizer_tb.sv
// Self-checking bench for the colour sensor normaliser: drives readings,
// predicts lamp, capture and levels, and checks every result beat.
// Depends on csn_pkg, csn_if and the color_sensor_normalizer RTL.
`timescale 1ns / 1ps

module color_sensor_normalizer_tb;

   localparam int CW = csn_pkg::COUNT_WIDTH;
   localparam int LW = csn_pkg::LEVEL_WIDTH;
   localparam int XW = csn_pkg::CSR_INDEX_WIDTH;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_OFF_LONG  = 400;
   localparam int PHASE_ITEMS    = 215;
   localparam logic [XW-1:0] CSR_UNUSED_INDEX = 4'hF;

   typedef struct {
      logic          paused;
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
      logic [CW-1:0] clear;
      int unsigned   gap;
      bit            drain_first;
   } sensor_reading_type;

   typedef struct packed {
      logic          lamp_on;
      logic          color_valid;
      logic [LW-1:0] red;
      logic [LW-1:0] green;
      logic [LW-1:0] blue;
   } normalised_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   logic [XW-1:0] csr_index        = '0;
   logic [CW-1:0] csr_write_data   = '0;

   csn_req_if req_bus ();
   csn_rsp_if rsp_bus ();

   color_sensor_normalizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies, written only while the block is idle.
   logic [CW-1:0] dark_level    = csn_pkg::DARK_THRESHOLD_RESET;
   logic [CW-1:0] band_low      = csn_pkg::BRIGHT_LOW_RESET;
   logic [CW-1:0] band_high     = csn_pkg::BRIGHT_HIGH_RESET;
   logic [CW-1:0] stable_window = csn_pkg::STABILITY_WINDOW_RESET;

   // Predicted state of the lamp and the captured colour.
   logic          lamp_state  = 1'b0;
   logic          colour_held = 1'b0;
   logic [CW-1:0] prior_clear = '0;
   logic [CW-1:0] held_red    = '0;
   logic [CW-1:0] held_green  = '0;
   logic [CW-1:0] held_blue   = '0;

   sensor_reading_type    pending_readings[$];
   normalised_result_type expected_results[$];
   sensor_reading_type    offered_reading;
   sensor_reading_type    taken_reading;

   int unsigned readings_queued   = 0;
   int unsigned readings_accepted = 0;
   int unsigned results_seen      = 0;
   int unsigned mismatches        = 0;
   int unsigned quiet_cycles      = 0;
   int          send_gap_max      = 18;
   int          stall_max         = 18;
   int          hold_off_request  = 0;
   int          hold_left         = 0;
   int          stall_left        = 0;
   logic        req_taken         = 1'b0;
   logic        rsp_taken         = 1'b0;
   logic [CW-1:0] gen_prior_clear = '0;

   always #4 clock = ~clock;

   // Level of one held channel against the current clear count.
   function automatic logic [LW-1:0] scaled_level(input logic [CW-1:0] held,
                                                  input logic [CW-1:0] clear);
      logic [CW+LW-1:0] quotient;
      if (clear == '0) return csn_pkg::LEVEL_MAX;
      quotient = {held, {LW{1'b0}}} / clear;
      return (quotient > csn_pkg::LEVEL_MAX) ? csn_pkg::LEVEL_MAX : quotient[LW-1:0];
   endfunction

   // Advances the predicted state by one reading and returns its result.
   function automatic normalised_result_type predict_result(input sensor_reading_type r);
      normalised_result_type res;
      logic [CW-1:0] diff;
      res = '0;
      if (r.paused) begin
         res.lamp_on = lamp_state;
         return res;
      end
      if (r.clear != '0 && r.clear < dark_level) begin
         lamp_state = 1'b1;
      end else if (r.clear > band_low && r.clear < band_high) begin
         lamp_state = 1'b0;
      end
      if (lamp_state) begin
         diff = (prior_clear >= r.clear) ? prior_clear - r.clear : r.clear - prior_clear;
         if (diff < stable_window) begin
            colour_held = 1'b1;
            held_red    = r.red;
            held_green  = r.green;
            held_blue   = r.blue;
         end
         prior_clear = r.clear;
      end else begin
         colour_held = 1'b0;
      end
      res.lamp_on = lamp_state;
      if (colour_held) begin
         res.color_valid = 1'b1;
         res.red         = scaled_level(held_red, r.clear);
         res.green       = scaled_level(held_green, r.clear);
         res.blue        = scaled_level(held_blue, r.clear);
      end
      return res;
   endfunction

   // Compares one result beat with the oldest expectation.
   task automatic check_result(input normalised_result_type got);
      normalised_result_type want;
      results_seen++;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d arrived with nothing expected", results_seen);
         return;
      end
      want = expected_results.pop_front();
      if (got.lamp_on !== want.lamp_on || got.color_valid !== want.color_valid ||
          got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"result %0d: expected lamp=%0b valid=%0b r=%0d g=%0d b=%0d, ",
                      "got lamp=%0b valid=%0b r=%0d g=%0d b=%0d"},
                     results_seen, want.lamp_on, want.color_valid, want.red, want.green,
                     want.blue, got.lamp_on, got.color_valid, got.red, got.green, got.blue);
      end
   endtask

   // Monitor: records accepted beats on both channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         rsp_taken <= rsp_bus.valid && rsp_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready)
            check_result({rsp_bus.lamp_on, rsp_bus.color_valid, rsp_bus.red_level,
                          rsp_bus.green_level, rsp_bus.blue_level});
         if (req_bus.valid && req_bus.ready) begin
            taken_reading.paused = req_bus.paused;
            taken_reading.red    = req_bus.red_count;
            taken_reading.green  = req_bus.green_count;
            taken_reading.blue   = req_bus.blue_count;
            taken_reading.clear  = req_bus.clear_count;
            expected_results.push_back(predict_result(taken_reading));
            readings_accepted++;
         end
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("color_sensor_normalizer_tb: FAIL");
            $finish;
         end
      end
   end

   // Driver: offers readings from the queue, honouring gaps and drain requests.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
         // The current beat is held until it is taken.
      end else if (pending_readings.size() == 0) begin
         req_bus.valid <= 1'b0;
      end else if (pending_readings[0].gap != 0) begin
         pending_readings[0].gap = pending_readings[0].gap - 1;
         req_bus.valid <= 1'b0;
      end else if (pending_readings[0].drain_first && expected_results.size() != 0) begin
         req_bus.valid <= 1'b0;
      end else begin
         offered_reading = pending_readings.pop_front();
         req_bus.valid       <= 1'b1;
         req_bus.paused      <= offered_reading.paused;
         req_bus.red_count   <= offered_reading.red;
         req_bus.green_count <= offered_reading.green;
         req_bus.blue_count  <= offered_reading.blue;
         req_bus.clear_count <= offered_reading.clear;
      end
   end

   // Receiver: random stalls per result, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_request > 0) begin
         hold_left        = hold_off_request;
         hold_off_request = 0;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_taken) begin
         stall_left = $urandom_range(0, stall_max);
         rsp_bus.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= (stall_left == 0);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic queue_reading(input logic paused, input logic [CW-1:0] red,
                                input logic [CW-1:0] green,
                                input logic [CW-1:0] blue,
                                input logic [CW-1:0] clear, input bit drain_first);
      sensor_reading_type r;
      r.paused      = paused;
      r.red         = red;
      r.green       = green;
      r.blue        = blue;
      r.clear       = clear;
      r.gap         = $urandom_range(0, send_gap_max);
      r.drain_first = drain_first;
      pending_readings.push_back(r);
      readings_queued++;
   endtask

   // One register write, with the enable dropped on the following cycle.
   task automatic write_register(input logic [XW-1:0] index,
                                 input logic [CW-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         csn_pkg::CSR_DARK_THRESHOLD:   dark_level    = data;
         csn_pkg::CSR_BRIGHT_LOW:       band_low      = data;
         csn_pkg::CSR_BRIGHT_HIGH:      band_high     = data;
         csn_pkg::CSR_STABILITY_WINDOW: stable_window = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CW-1:0] dark, input logic [CW-1:0] low,
                                 input logic [CW-1:0] high,
                                 input logic [CW-1:0] window);
      write_register(csn_pkg::CSR_DARK_THRESHOLD, dark);
      write_register(csn_pkg::CSR_BRIGHT_LOW, low);
      write_register(csn_pkg::CSR_BRIGHT_HIGH, high);
      write_register(csn_pkg::CSR_STABILITY_WINDOW, window);
   endtask

   // Waits until every reading is taken and answered, then lets the block settle.
   task automatic wait_idle();
      while (readings_accepted != readings_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Colour count: often below the clear count so that levels do not saturate.
   function automatic logic [CW-1:0] random_count(input logic [CW-1:0] clear);
      case ($urandom_range(0, 3))
         0:       return CW'($urandom_range(0, clear));
         1:       return CW'($urandom);
         2:       return $urandom_range(0, 1) ? '1 : '0;
         default: return CW'($urandom_range(0, 255));
      endcase
   endfunction

   // Clear count biased towards dark readings, the bright band and small steps.
   function automatic logic [CW-1:0] random_clear();
      int step;
      int value;
      case ($urandom_range(0, 9))
         0, 1, 2: value = (dark_level > 1) ? int'($urandom_range(1, dark_level - 1))
                                           : int'($urandom);
         3:       value = (band_high > band_low + 1) ?
                          int'($urandom_range(band_low + 1, band_high - 1)) : int'($urandom);
         4, 5, 6: begin
            step  = int'($urandom_range(0, stable_window));
            value = $urandom_range(0, 1) ? int'(gen_prior_clear) + step
                                         : int'(gen_prior_clear) - step;
            if (value < 0) value = 0;
            if (value > 65535) value = 65535;
         end
         7:       value = $urandom_range(0, 1) ? 65535 : 0;
         default: value = int'($urandom);
      endcase
      gen_prior_clear = value[CW-1:0];
      return gen_prior_clear;
   endfunction

   task automatic queue_random_readings(input int count);
      logic [CW-1:0] clear;
      for (int i = 0; i < count; i++) begin
         clear = random_clear();
         queue_reading($urandom_range(0, 9) == 0, random_count(clear), random_count(clear),
                       random_count(clear), clear, $urandom_range(0, 39) == 0);
      end
   endtask

   // Directed cases: field extremes, lamp thresholds, capture and the odd registers.
   task automatic run_directed();
      queue_reading(1'b1, '1, '1, '1, '1, 1'b0);
      queue_reading(1'b0, 16'd5, 16'd5, 16'd5, 16'd0, 1'b0);
      queue_reading(1'b0, 16'hFFFF, 16'd0, 16'd3, 16'd30, 1'b0);
      queue_reading(1'b0, 16'd20, 16'd10, 16'd1, 16'd30, 1'b0);
      queue_reading(1'b1, 16'h1234, 16'h5678, 16'h9ABC, 16'd30, 1'b0);
      // Zero clear with the lamp on saturates every level.
      queue_reading(1'b0, 16'd100, 16'd200, 16'd0, 16'd0, 1'b1);
      queue_reading(1'b0, 16'd7, 16'd7, 16'd7, 16'd2000, 1'b0);
      queue_reading(1'b0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 1'b0);
      queue_reading(1'b0, 16'd1, 16'd1, 16'd1, 16'd7000, 1'b0);
      queue_reading(1'b0, 16'd9, 16'd9, 16'd9, 16'd5000, 1'b0);
      queue_reading(1'b0, 16'd40, 16'd50, 16'd60, 16'd59, 1'b0);
      queue_reading(1'b0, 16'd40, 16'd50, 16'd60, 16'd60, 1'b0);
      queue_reading(1'b0, 16'd1, 16'd1, 16'd1, 16'd9000, 1'b0);
      queue_reading(1'b0, 16'd1, 16'd1, 16'd1, 16'd8999, 1'b0);
      wait_idle();
      // A zero window means no reading is ever stable.
      write_register(csn_pkg::CSR_STABILITY_WINDOW, 16'd0);
      queue_reading(1'b0, 16'd8, 16'd8, 16'd8, 16'd10, 1'b0);
      queue_reading(1'b0, 16'd8, 16'd8, 16'd8, 16'd10, 1'b0);
      queue_reading(1'b0, 16'd8, 16'd8, 16'd8, 16'd11, 1'b0);
      wait_idle();
      // Inverted bright band keeps the lamp on; a write beyond the last index is ignored.
      write_register(csn_pkg::CSR_BRIGHT_LOW, 16'd9000);
      write_register(csn_pkg::CSR_BRIGHT_HIGH, 16'd5000);
      write_register(csn_pkg::CSR_STABILITY_WINDOW, 16'd1000);
      write_register(CSR_UNUSED_INDEX, 16'd0);
      queue_reading(1'b0, 16'd500, 16'd600, 16'd700, 16'd7000, 1'b0);
      queue_reading(1'b0, 16'd500, 16'd600, 16'd700, 16'd7010, 1'b0);
      queue_reading(1'b0, 16'd500, 16'd600, 16'd700, 16'd5001, 1'b0);
      wait_idle();
   endtask

   // Sequence of phases; registers change only between them.
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.paused      = 1'b0;
      req_bus.red_count   = '0;
      req_bus.green_count = '0;
      req_bus.blue_count  = '0;
      req_bus.clear_count = '0;
      rsp_bus.ready       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      apply_settings(16'd60, 16'd5000, 16'd9000, 16'd1000);
      queue_random_readings(PHASE_ITEMS);
      wait_idle();

      // Top values in every register but the bright low bound, which is zero, with no idling on either side.
      send_gap_max = 0;
      stall_max    = 0;
      apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
      queue_random_readings(PHASE_ITEMS);
      wait_idle();

      // All registers zero: the lamp never turns on and the band is empty.
      send_gap_max = 18;
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
      queue_random_readings(PHASE_ITEMS);
      wait_idle();

      // Receiver holds off for a long stretch while readings keep coming.
      send_gap_max = 0;
      stall_max    = 18;
      apply_settings(16'd3000, 16'd20000, 16'd40000, 16'd500);
      hold_off_request = HOLD_OFF_LONG;
      queue_random_readings(40);
      wait_idle();
      send_gap_max = 18;
      queue_random_readings(PHASE_ITEMS - 40);
      wait_idle();

      apply_settings(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
      queue_random_readings(PHASE_ITEMS);
      wait_idle();

      send_gap_max = 5;
      stall_max    = 5;
      apply_settings(16'd40000, 16'd50000, 16'd45000, 16'd2);
      queue_random_readings(PHASE_ITEMS);
      wait_idle();

      if (mismatches == 0)
         $display("color_sensor_normalizer_tb: PASS");
      else
         $display("color_sensor_normalizer_tb: FAIL");
      $finish;
   end

endmodule

// File: color_sensor_normalizer.f
+incdir+rtl
rtl/csn_pkg.sv
rtl/csn_if.sv
rtl/color_sensor_normalizer.sv
bench/color_sensor_normalizer_tb.sv
